[src/idq_pkg.sv]
// ----------------------------------------------------------------------------
// idq_pkg
// shared types and sizing constants for the indexed deque
// ----------------------------------------------------------------------------
package idq_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_W     = 32;
    localparam int POS_W      = 6;
    localparam int LEN_W      = 7;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;
    // only cells reachable by the position field feed the read fold
    localparam int READ_CELLS = (DEPTH < (1 << POS_W)) ? DEPTH : (1 << POS_W);
    localparam int GROUP_SZ   = 8;
    localparam int NUM_GROUPS = (READ_CELLS + GROUP_SZ - 1) / GROUP_SZ;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_BACK  = 2'd1,
        MODE_REMOVE     = 2'd2,
        MODE_READ       = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // operation broadcast to every cell
    typedef struct packed {
        logic              en;
        logic              ok;
        mode_t             mode;
        logic [DATA_W-1:0] value;
        logic [CMP_W-1:0]  pos;
        logic [CMP_W-1:0]  count;
    } op_t;

endpackage

[src/indexed_deque.sv]
// ----------------------------------------------------------------------------
// indexed_deque
// bounded deque of signed 32-bit entries with indexed remove and read
// ----------------------------------------------------------------------------
// s_ channel carries one operation per item: push front, push back, remove
// at a position or read at a position. m_ channel returns one result item
// per operation with the read value, the length afterwards and a status.
// Entries live in a row of DEPTH cells; a push front shifts the row toward
// the back, a remove shifts every cell from the position onward toward the
// front, all cells in the same clock.
// On the way to m_tvalid the item is registered on acceptance, the execute stage
// updates the cells and ORs the read taps in groups of eight into the fold
// registers, then the fold stage ORs the groups into the output register.
// Throughput is one item per cycle while m_tready holds high; all cells update
// together, so the next operation sees the previous one's effect at once.
// Reset empties the deque (length zero); entry contents are not cleared.
// When the receiver stalls the output register holds its item, the fold
// and execute stages fill behind it, and s_tready drops once all are full.
// ----------------------------------------------------------------------------
module indexed_deque import idq_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // mode[1:0], value[33:2], position[39:34]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // read_value[31:0], length_now[38:32], status[40:39], zero pad above
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    // execute stage
    logic              exec_valid_reg;
    mode_t             mode_reg;
    logic [DATA_W-1:0] value_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    // fold stage
    logic              fold_valid_reg;
    logic [DATA_W-1:0] group_reg [NUM_GROUPS];
    logic [LEN_W-1:0]  fold_len_reg;
    status_t           fold_status_reg;

    // output register
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_rd_reg;
    logic [LEN_W-1:0]  out_len_reg;
    status_t           out_status_reg;

    logic              exec_adv;
    logic              fold_adv;
    logic              fold_free;
    status_t           exec_status;
    op_t               op;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic [DATA_W-1:0] group_or [NUM_GROUPS];
    logic [DATA_W-1:0] fold_or;

    logic [DATA_W-1:0] cell_data [DEPTH];
    logic [DATA_W-1:0] cell_tap  [READ_CELLS];

    assign fold_adv  = fold_valid_reg && (!out_valid_reg || m_tready);
    assign fold_free = !fold_valid_reg || fold_adv;
    assign exec_adv  = exec_valid_reg && fold_free;
    assign s_tready  = !exec_valid_reg || exec_adv;

    assign pos_ext = CMP_W'(pos_reg);
    assign cnt_ext = CMP_W'(count_reg);

    always_comb begin
        exec_status = ST_DONE;
        case (mode_reg)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                if (count_reg == CNT_W'(DEPTH)) begin
                    exec_status = ST_FULL;
                end
            end
            MODE_REMOVE, MODE_READ: begin
                if (pos_ext >= cnt_ext) begin
                    exec_status = ST_RANGE;
                end
            end
            default: begin
                exec_status = ST_DONE;
            end
        endcase
    end

    always_comb begin
        count_next = count_reg;
        if (exec_status == ST_DONE) begin
            case (mode_reg)
                MODE_PUSH_FRONT, MODE_PUSH_BACK: count_next = count_reg + CNT_W'(1);
                MODE_REMOVE:                     count_next = count_reg - CNT_W'(1);
                default:                         count_next = count_reg;
            endcase
        end
    end

    always_comb begin
        op.en    = exec_adv;
        op.ok    = exec_valid_reg && (exec_status == ST_DONE);
        op.mode  = mode_reg;
        op.value = value_reg;
        op.pos   = pos_ext;
        op.count = cnt_ext;
    end

    // row of cells
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [DATA_W-1:0] left_in;
        logic [DATA_W-1:0] right_in;

        if (k == 0) begin : g_first
            assign left_in = value_reg;
        end else begin : g_mid
            assign left_in = cell_data[k-1];
        end

        if (k == DEPTH - 1) begin : g_last
            assign right_in = cell_data[k];
        end else begin : g_inner
            assign right_in = cell_data[k+1];
        end

        if (k < READ_CELLS) begin : g_tap
            idq_cell u_cell (
                .aclk       (aclk),
                .op         (op),
                .idx        (IDX_W'(k)),
                .left_data  (left_in),
                .right_data (right_in),
                .data       (cell_data[k]),
                .tap        (cell_tap[k])
            );
        end else begin : g_notap
            idq_cell u_cell (
                .aclk       (aclk),
                .op         (op),
                .idx        (IDX_W'(k)),
                .left_data  (left_in),
                .right_data (right_in),
                .data       (cell_data[k]),
                .tap        ()
            );
        end
    end

    // first level of the read fold: eight taps per group
    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            group_or[g] = '0;
            for (int j = 0; j < GROUP_SZ; j++) begin
                if (g * GROUP_SZ + j < READ_CELLS) begin
                    group_or[g] = group_or[g] | cell_tap[g * GROUP_SZ + j];
                end
            end
        end
    end

    always_comb begin
        fold_or = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            fold_or = fold_or | group_reg[g];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exec_valid_reg <= 1'b0;
            fold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            count_reg      <= '0;
        end else begin
            if (s_tready) begin
                exec_valid_reg <= s_tvalid;
            end
            if (fold_free) begin
                fold_valid_reg <= exec_adv;
            end
            if (!out_valid_reg || m_tready) begin
                out_valid_reg <= fold_adv;
            end
            if (exec_adv) begin
                count_reg <= count_next;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            mode_reg  <= mode_t'(s_tdata[1:0]);
            value_reg <= s_tdata[33:2];
            pos_reg   <= s_tdata[39:34];
        end
        if (exec_adv) begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
                group_reg[g] <= group_or[g];
            end
            fold_len_reg    <= LEN_W'(count_next);
            fold_status_reg <= exec_status;
        end
        if (fold_adv) begin
            out_rd_reg     <= fold_or;
            out_len_reg    <= fold_len_reg;
            out_status_reg <= fold_status_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - DATA_W - LEN_W - 2)'(0), out_status_reg,
                       out_len_reg, out_rd_reg};

endmodule

[src/idq_cell.sv]
// ----------------------------------------------------------------------------
// idq_cell
// one entry of the deque: holds, loads, or takes a neighbor's entry
// ----------------------------------------------------------------------------
module idq_cell import idq_pkg::*; (
    input  logic              aclk,
    input  op_t               op,
    input  logic [IDX_W-1:0]  idx,
    input  logic [DATA_W-1:0] left_data,
    input  logic [DATA_W-1:0] right_data,
    output logic [DATA_W-1:0] data,
    output logic [DATA_W-1:0] tap
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic [CMP_W-1:0]  idx_ext;

    assign idx_ext = CMP_W'(idx);

    always_comb begin
        data_next = data_reg;
        if (op.en && op.ok) begin
            case (op.mode)
                MODE_PUSH_FRONT: begin
                    // cell zero sees the pushed item on its left input
                    data_next = left_data;
                end
                MODE_PUSH_BACK: begin
                    if (idx_ext == op.count) begin
                        data_next = op.value;
                    end
                end
                MODE_REMOVE: begin
                    if (idx_ext >= op.pos) begin
                        data_next = right_data;
                    end
                end
                default: begin
                    data_next = data_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign tap  = (op.mode == MODE_READ && op.ok && idx_ext == op.pos) ? data_reg : '0;

endmodule
